// ===== rtl/core/hbr_pkg.sv =====
// ----------------------------------------------------------------------------
// hbr_pkg: shared definitions for the byte histogram report unit
// Register indexes, function codes, report order codes and the control
// bundle that the sequencer hands to the rank compare unit.
// ----------------------------------------------------------------------------
package hbr_pkg;

  // Configuration register indexes.
  localparam logic CFG_ORDER_MODE = 1'b0;
  localparam logic CFG_ROW_LIMIT  = 1'b1;

  // Input item function codes.
  localparam logic FUNC_COUNT = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  // Report orders.
  localparam logic MODE_ORDINAL = 1'b0;
  localparam logic MODE_RANKED  = 1'b1;

  localparam int unsigned LIMIT_BITS = 9;
  localparam logic [LIMIT_BITS-1:0] ROW_LIMIT_RESET = 9'd256;
  localparam logic [LIMIT_BITS-1:0] ROWS_MAX        = 9'd511;

  // Control flags seen by the compare unit during a scan.
  typedef struct packed {
    logic mode;     // report order in force
    logic started;  // cursor holds the key of an earlier row
    logic found;    // a candidate row has already been kept in this scan
  } cmp_ctl_t;

endpackage

// ===== rtl/core/byte_histogram_ranked_report_unit.sv =====
// ----------------------------------------------------------------------------
// byte_histogram_ranked_report_unit: byte histogram with a ranked report
// Counts byte values in a saturating counter table and reads the table back
// as report rows, in symbol order or ranked by count.
// ----------------------------------------------------------------------------
// The counters live in a single RAM with registered read data, and one
// compare unit walks that RAM under a small sequencer, so the unit takes one
// input item at a time. A count item reads the counter, then writes the
// incremented value. A fetch item reads every entry of the table once
// through the compare unit, then puts the row into the output register; a
// fetch in ranked mode that has already reached row_limit skips the walk.
// A fetch that ends the report (report_done) is followed by a clearing
// sweep, one table entry per cycle, and the same sweep runs right after
// reset; in_ready stays low during both. The output register lets the unit
// take further items while a row waits to be taken; a fetch finishing while
// the register is still full waits for it. Configuration writes are taken on
// any cycle and should only be issued while the unit is idle.
// ----------------------------------------------------------------------------
module byte_histogram_ranked_report_unit #(
  parameter int NUM_SYMBOLS = 256,
  parameter int COUNT_BITS  = 8
) (
  input  logic       clk,
  input  logic       rst,
  // Input items
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       func,
  input  logic [7:0] symbol,
  // Result items
  output logic       out_valid,
  input  logic       out_ready,
  output logic       row_valid,
  output logic [7:0] row_symbol,
  output logic [7:0] row_count,
  output logic       saturated,
  output logic       report_done,
  // Configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data
);
  import hbr_pkg::*;

  localparam int SYM_BITS = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);
  localparam logic [SYM_BITS:0]     SCAN_END   = (SYM_BITS+1)'(NUM_SYMBOLS);
  localparam logic [SYM_BITS-1:0]   CLEAR_LAST = SYM_BITS'(NUM_SYMBOLS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,  // sweep zeros through the table
    ST_IDLE,   // waiting for an item
    ST_INC,    // counter read back, write the increment
    ST_SCAN,   // walk the table through the compare unit
    ST_FIN     // hand the row to the output register, move the cursor
  } state_t;

  state_t state;

  // Configuration registers.
  logic                  order_mode;
  logic [LIMIT_BITS-1:0] row_limit;

  // Report cursor.
  logic [COUNT_BITS-1:0] prev_count;
  logic [SYM_BITS-1:0]   prev_symbol;
  logic                  cursor_started;
  logic [LIMIT_BITS-1:0] rows_emitted;

  // Scan bookkeeping.
  logic [SYM_BITS:0]     scan_cnt;
  logic                  pipe_valid;   // rd_data belongs to pipe_sym this cycle
  logic [SYM_BITS-1:0]   pipe_sym;
  logic                  found;
  logic [COUNT_BITS-1:0] best_count;
  logic [SYM_BITS-1:0]   best_symbol;
  logic [SYM_BITS-1:0]   clear_cnt;
  logic [SYM_BITS-1:0]   inc_addr;

  // Table RAM ports.
  logic                  ram_we;
  logic [SYM_BITS-1:0]   ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [SYM_BITS-1:0]   ram_raddr;
  logic [COUNT_BITS-1:0] rd_data;

  cmp_ctl_t cmp_ctl;
  logic     take;

  logic in_fire;
  logic out_free;
  logic sym_in_range;
  logic limit_hit;

  assign in_ready     = (state == ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign in_fire      = in_valid && in_ready;
  assign out_free     = !out_valid || out_ready;
  assign sym_in_range = (32'(symbol) < 32'(NUM_SYMBOLS));
  assign limit_hit    = (order_mode == MODE_RANKED) && (rows_emitted >= row_limit);

  assign cmp_ctl.mode    = order_mode;
  assign cmp_ctl.started = cursor_started;
  assign cmp_ctl.found   = found;

  hbr_rank_cmp #(
    .SYM_BITS   (SYM_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_cmp (
    .ctl         (cmp_ctl),
    .prev_count  (prev_count),
    .prev_symbol (prev_symbol),
    .best_count  (best_count),
    .cand_count  (rd_data),
    .cand_symbol (pipe_sym),
    .take        (take)
  );

  hbr_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_SYMBOLS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // RAM port steering. The write port serves the clearing sweep and the
  // counter increment; the read port serves counting and the scan.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clear_cnt;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = scan_cnt[SYM_BITS-1:0];
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        ram_re    = in_fire && (func == FUNC_COUNT) && sym_in_range;
        ram_raddr = SYM_BITS'(symbol);
      end
      ST_INC: begin
        ram_we    = (rd_data != COUNT_MAX);
        ram_waddr = inc_addr;
        ram_wdata = rd_data + COUNT_ONE;
      end
      ST_SCAN: begin
        ram_re = (scan_cnt != SCAN_END);
      end
      ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      order_mode     <= MODE_ORDINAL;
      row_limit      <= ROW_LIMIT_RESET;
      prev_count     <= '0;
      prev_symbol    <= '0;
      cursor_started <= 1'b0;
      rows_emitted   <= '0;
      scan_cnt       <= '0;
      pipe_valid     <= 1'b0;
      found          <= 1'b0;
      clear_cnt      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ORDER_MODE: order_mode <= cfg_data[0];
          CFG_ROW_LIMIT:  row_limit  <= cfg_data;
          default: begin
          end
        endcase
      end

      // In ST_FIN a taken row is always replaced by the next one below.
      if (out_valid && out_ready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          if (clear_cnt == CLEAR_LAST) begin
            clear_cnt <= '0;
            state     <= ST_IDLE;
          end else begin
            clear_cnt <= clear_cnt + 1'b1;
          end
        end

        ST_IDLE: begin
          if (in_fire) begin
            if (func == FUNC_COUNT) begin
              inc_addr <= SYM_BITS'(symbol);
              // A symbol beyond the table is dropped.
              if (sym_in_range) begin
                state <= ST_INC;
              end
            end else begin
              found      <= 1'b0;
              scan_cnt   <= '0;
              pipe_valid <= 1'b0;
              state      <= limit_hit ? ST_FIN : ST_SCAN;
            end
          end
        end

        ST_INC: begin
          state <= ST_IDLE;
        end

        ST_SCAN: begin
          // Issue one read per cycle; evaluate the entry read last cycle.
          if (scan_cnt != SCAN_END) begin
            pipe_valid <= 1'b1;
            pipe_sym   <= scan_cnt[SYM_BITS-1:0];
            scan_cnt   <= scan_cnt + 1'b1;
          end else begin
            pipe_valid <= 1'b0;
            if (!pipe_valid) begin
              state <= ST_FIN;
            end
          end
          if (pipe_valid && take) begin
            found       <= 1'b1;
            best_count  <= rd_data;
            best_symbol <= pipe_sym;
          end
        end

        ST_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (found) begin
              row_valid      <= 1'b1;
              row_symbol     <= 8'(best_symbol);
              row_count      <= 8'(best_count);
              saturated      <= (best_count == COUNT_MAX);
              report_done    <= 1'b0;
              prev_count     <= best_count;
              prev_symbol    <= best_symbol;
              cursor_started <= 1'b1;
              if (rows_emitted != ROWS_MAX) begin
                rows_emitted <= rows_emitted + 1'b1;
              end
              state <= ST_IDLE;
            end else begin
              // End of report: empty row, then wipe table and cursor.
              row_valid      <= 1'b0;
              row_symbol     <= '0;
              row_count      <= '0;
              saturated      <= 1'b0;
              report_done    <= 1'b1;
              prev_count     <= '0;
              prev_symbol    <= '0;
              cursor_started <= 1'b0;
              rows_emitted   <= '0;
              clear_cnt      <= '0;
              state          <= ST_CLEAR;
            end
          end
        end

        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // The scan never writes the table, so every entry is seen as it stood.
  a_scan_read_only: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !ram_we)
    else $error("table written during a report scan");

  // A new item is taken only once the scan pipeline has drained.
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !pipe_valid)
    else $error("item accepted with a table read in flight");

  // An end-of-report result is an empty row.
  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && report_done) |-> (!row_valid && (row_count == '0) && !saturated))
    else $error("end-of-report result carries row data");

  // Finishing a report starts the clearing sweep with a reset cursor.
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FIN) && out_free && !found) |=>
      ((state == ST_CLEAR) && !cursor_started && (rows_emitted == '0)))
    else $error("report end did not clear the table and cursor");

endmodule

// ===== rtl/core/hbr_ram.sv =====
// ----------------------------------------------------------------------------
// hbr_ram: generic single-clock RAM
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module hbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/hbr_rank_cmp.sv =====
// ----------------------------------------------------------------------------
// hbr_rank_cmp: report order compare unit
// Decides whether a table entry is nonzero, lies past the cursor in the
// current order and beats the best candidate kept so far in this scan.
// ----------------------------------------------------------------------------
module hbr_rank_cmp #(
  parameter int SYM_BITS   = 8,
  parameter int COUNT_BITS = 8
) (
  input  hbr_pkg::cmp_ctl_t       ctl,
  input  logic [COUNT_BITS-1:0]   prev_count,
  input  logic [SYM_BITS-1:0]     prev_symbol,
  input  logic [COUNT_BITS-1:0]   best_count,
  input  logic [COUNT_BITS-1:0]   cand_count,
  input  logic [SYM_BITS-1:0]     cand_symbol,
  output logic                    take
);
  import hbr_pkg::*;

  logic nonzero;
  logic past_cursor;
  logic better;

  always_comb begin
    nonzero = (cand_count != '0);
    if (ctl.mode == MODE_RANKED) begin
      past_cursor = !ctl.started || (cand_count < prev_count) ||
                    ((cand_count == prev_count) && (cand_symbol > prev_symbol));
      // Entries arrive in ascending symbol order, so a tie keeps the first.
      better      = !ctl.found || (cand_count > best_count);
    end else begin
      past_cursor = !ctl.started || (cand_symbol > prev_symbol);
      better      = !ctl.found;
    end
    take = nonzero && past_cursor && better;
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the byte histogram ranked report unit
// Sends count and fetch items under random flow control, predicts every
// report row from its own model of the counter table and report cursor, and
// checks each row as it leaves the unit, in both report orders and under
// several row limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import hbr_pkg::*;

  localparam int NSYM         = 256;
  localparam logic [7:0] COUNT_TOP = 8'hFF;
  // A fetch walks the whole table and a finished report adds a clearing sweep
  // of the table, so this covers any work in flight.
  localparam int SETTLE_CYCLES = 2 * NSYM + 100;
  localparam int DRAIN_BOUND   = 20000;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int LIMIT_CYCLES  = 4000000;
  localparam int SHOW_MAX      = 10;

  typedef struct packed {
    logic       row_valid;
    logic [7:0] symbol;
    logic [7:0] count;
    logic       saturated;
    logic       done;
  } report_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       func = FUNC_COUNT;
  logic [7:0] symbol = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       row_valid;
  logic [7:0] row_symbol;
  logic [7:0] row_count;
  logic       saturated;
  logic       report_done;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = CFG_ORDER_MODE;
  logic [8:0] cfg_data = 9'd0;

  byte_histogram_ranked_report_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .symbol      (symbol),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .row_valid   (row_valid),
    .row_symbol  (row_symbol),
    .row_count   (row_count),
    .saturated   (saturated),
    .report_done (report_done),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Local copy of the unit's state. The counter table, the cursor key of the
  // last row handed out and the rows counter evolve exactly as the unit's
  // must, one accepted item at a time.
  // --------------------------------------------------------------------------
  logic [7:0] tally [NSYM];
  logic [7:0] cursor_count = 8'd0;
  logic [7:0] cursor_symbol = 8'd0;
  logic       cursor_live = 1'b0;
  logic [8:0] rows_out = 9'd0;
  logic       report_mode = MODE_ORDINAL;
  logic [8:0] report_limit = ROW_LIMIT_RESET;
  logic       report_ended = 1'b0;

  report_row_t pending_rows[$];
  int          fail_count = 0;
  int          shown = 0;
  int          items_sent = 0;
  int          cycle_count = 0;
  logic        in_gaps_on = 1'b0;
  logic        out_stalls_on = 1'b0;
  int          stall_left = 0;

  initial begin
    foreach (tally[i]) tally[i] = 8'd0;
  end

  function automatic void clear_tally();
    foreach (tally[i]) tally[i] = 8'd0;
    cursor_count  = 8'd0;
    cursor_symbol = 8'd0;
    cursor_live   = 1'b0;
    rows_out      = 9'd0;
  endfunction

  // Works out the row that the next fetch returns and moves the cursor past
  // it. In ordinal order the first nonzero symbol above the cursor wins; in
  // ranked order the highest count among the keys that rank after the cursor
  // wins, and the lowest symbol wins a tie since the scan runs upward and
  // only a strictly larger count replaces the kept candidate.
  function automatic report_row_t next_report_row();
    report_row_t row;
    logic        found;
    logic [7:0]  pick;
    logic [7:0]  best;
    logic [7:0]  c;
    row   = '0;
    found = 1'b0;
    pick  = 8'd0;
    best  = 8'd0;
    if (!(report_mode == MODE_RANKED && rows_out >= report_limit)) begin
      for (int s = 0; s < NSYM; s++) begin
        c = tally[s];
        if (c != 0) begin
          if (report_mode == MODE_ORDINAL) begin
            if (!found && !(cursor_live && s <= cursor_symbol)) begin
              found = 1'b1;
              pick  = 8'(s);
            end
          end else if (!cursor_live || c < cursor_count ||
                       (c == cursor_count && s > cursor_symbol)) begin
            if (!found || c > best) begin
              found = 1'b1;
              best  = c;
              pick  = 8'(s);
            end
          end
        end
      end
    end
    if (found) begin
      row.row_valid = 1'b1;
      row.symbol    = pick;
      row.count     = tally[pick];
      row.saturated = (tally[pick] == COUNT_TOP);
      cursor_count  = tally[pick];
      cursor_symbol = pick;
      cursor_live   = 1'b1;
      if (rows_out != ROWS_MAX) rows_out = rows_out + 9'd1;
      report_ended = 1'b0;
    end else begin
      // Nothing left: an empty row with done, and the table starts over.
      row.done     = 1'b1;
      report_ended = 1'b1;
      clear_tally();
    end
    return row;
  endfunction

  // Most idle stretches are short, some longer, and a rare one is long.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Input side. An item's payload is set together with valid at a clock edge
  // and held until the edge where in_ready is seen high. Valid is left high
  // after an acceptance so that back-to-back items need no second assignment
  // in the same step; it is dropped only when a gap or a pause follows.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic f, input logic [7:0] s);
    int gap;
    gap = 0;
    if (in_gaps_on && $urandom_range(0, 99) < 35) gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    symbol   <= s;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (f == FUNC_COUNT) begin
      if (tally[s] != COUNT_TOP) tally[s] = tally[s] + 8'd1;
    end else begin
      pending_rows.push_back(next_report_row());
    end
  endtask

  // Holds the sender off until every expected row has come back.
  task automatic wait_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_rows.size() != 0 && waited < DRAIN_BOUND);
    if (pending_rows.size() != 0) begin
      fail_count += pending_rows.size();
      $display("%0d expected rows never arrived", pending_rows.size());
      pending_rows.delete();
    end
  endtask

  // Count items leave no row behind, so after the last row the unit may still
  // be busy; the extra cycles let any table walk or clearing sweep finish.
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes are only issued with the unit settled. The closing edge
  // keeps a following write from dropping and raising valid in one step.
  task automatic write_register(input logic idx, input logic [8:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_ORDER_MODE) report_mode = value[0];
    else report_limit = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_order(input logic mode, input logic [8:0] limit);
    settle();
    write_register(CFG_ORDER_MODE, {8'($urandom_range(0, 255)), mode});
    write_register(CFG_ROW_LIMIT, limit);
  endtask

  task automatic fetch_rows(input int n);
    repeat (n) send_item(FUNC_FETCH, 8'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Output side: out_ready stalls at random while stalls are enabled, and a
  // checker takes each row at the edge where out_valid and out_ready are both
  // high and compares it with the oldest expected row.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (out_stalls_on && $urandom_range(0, 99) < 20) begin
      stall_left <= idle_len() - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    report_row_t got;
    report_row_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{row_valid, row_symbol, row_count, saturated, report_done};
      if (pending_rows.size() == 0) begin
        fail_count++;
        if (shown < SHOW_MAX) begin
          shown++;
          $display("unexpected row: valid=%b sym=%02h cnt=%0d sat=%b done=%b",
                   got.row_valid, got.symbol, got.count, got.saturated, got.done);
        end
      end else begin
        want = pending_rows.pop_front();
        if (got.row_valid !== want.row_valid || got.symbol !== want.symbol ||
            got.count !== want.count || got.saturated !== want.saturated ||
            got.done !== want.done) begin
          fail_count++;
          if (shown < SHOW_MAX) begin
            shown++;
            $display("row mismatch at %0t: expected valid=%b sym=%02h cnt=%0d sat=%b done=%b",
                     $realtime, want.row_valid, want.symbol, want.count,
                     want.saturated, want.done);
            $display("                        actual valid=%b sym=%02h cnt=%0d sat=%b done=%b",
                     got.row_valid, got.symbol, got.count, got.saturated, got.done);
          end
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Ordinal order: a fetch on an empty table ends at once, then the lowest
  // and highest byte values and a repeated byte come back in byte order.
  task automatic test_ordinal_order();
    set_order(MODE_ORDINAL, ROW_LIMIT_RESET);
    fetch_rows(1);
    send_item(FUNC_COUNT, 8'hFF);
    send_item(FUNC_COUNT, 8'h00);
    send_item(FUNC_COUNT, 8'h00);
    send_item(FUNC_COUNT, 8'h5A);
    fetch_rows(4);
  endtask

  // Ranked order with equal counts: the lower byte comes first on a tie.
  task automatic test_ranked_ties();
    set_order(MODE_RANKED, ROW_LIMIT_RESET);
    send_item(FUNC_COUNT, 8'h30);
    send_item(FUNC_COUNT, 8'h20);
    send_item(FUNC_COUNT, 8'h10);
    send_item(FUNC_COUNT, 8'h30);
    send_item(FUNC_COUNT, 8'h20);
    fetch_rows(4);
  endtask

  // A limit of zero ends the report before any row, a limit of one after
  // the first, and the widest limit lies beyond the table and never bites.
  task automatic test_row_limits();
    set_order(MODE_RANKED, 9'd0);
    send_item(FUNC_COUNT, 8'h42);
    fetch_rows(1);
    set_order(MODE_RANKED, 9'd1);
    send_item(FUNC_COUNT, 8'h01);
    send_item(FUNC_COUNT, 8'h02);
    fetch_rows(2);
    set_order(MODE_RANKED, 9'd511);
    send_item(FUNC_COUNT, 8'hA5);
    fetch_rows(2);
  endtask

  // Counters stop at their maximum and are flagged; two saturated counters
  // tie, and the one just below the top ranks after them unflagged.
  task automatic test_saturation();
    set_order(MODE_RANKED, ROW_LIMIT_RESET);
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b1;
    repeat (257) send_item(FUNC_COUNT, 8'hC3);
    repeat (255) send_item(FUNC_COUNT, 8'h3C);
    repeat (254) send_item(FUNC_COUNT, 8'h11);
    fetch_rows(4);
  endtask

  task automatic random_setting();
    logic [8:0] limit;
    case ($urandom_range(0, 6))
      0:       limit = 9'd0;
      1:       limit = 9'd1;
      2:       limit = 9'($urandom_range(2, 8));
      3:       limit = 9'd256;
      4:       limit = 9'd511;
      5:       limit = 9'($urandom_range(257, 510));
      default: limit = 9'($urandom_range(1, 256));
    endcase
    set_order(1'($urandom_range(0, 1)), limit);
  endtask

  // Rounds of counting from a small random set of bytes, followed by fetches
  // until the report ends. While a report runs, bytes are counted in place,
  // the order is switched, or the sender waits for every row; some reports
  // are left unfinished and some rounds are plain noise. Rounds go on until
  // the run as a whole has sent its share of items.
  task automatic test_random_reports();
    logic [7:0] pool [6];
    int         pool_n;
    int         guard;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) random_setting();
      in_gaps_on    = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      foreach (pool[i]) pool[i] = 8'($urandom_range(0, 255));
      pool_n = $urandom_range(1, 6);
      if ($urandom_range(0, 14) == 0) begin
        repeat ($urandom_range(1, 12))
          send_item($urandom_range(0, 1) ? FUNC_FETCH : FUNC_COUNT,
                    8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 24)) send_item(FUNC_COUNT, pool[$urandom_range(0, pool_n - 1)]);
        report_ended = 1'b0;
        guard = 0;
        while (!report_ended && guard < 300) begin
          guard++;
          case ($urandom_range(0, 19))
            0, 1: repeat ($urandom_range(1, 3))
                    send_item(FUNC_COUNT, pool[$urandom_range(0, pool_n - 1)]);
            2: begin
              settle();
              write_register(CFG_ORDER_MODE, {8'($urandom_range(0, 255)), ~report_mode});
            end
            3: wait_results();
            4: if ($urandom_range(0, 3) == 0) guard = 300;
            default: ;
          endcase
          fetch_rows(1);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset once, run the tests in turn, drain and judge.
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_ordinal_order();
    test_ranked_ties();
    test_row_limits();
    test_saturation();
    test_random_reports();
    settle();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
